FILE: rtl/srg_pkg.sv
// ----------------------------------------------------------------------------
// Subtractive random generator package
// Widths, constants and small helper functions shared by the generator files.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned RawW        = 30;
  localparam int unsigned RangeW      = 31;
  localparam int unsigned SeedW       = 32;
  localparam int unsigned ProdW       = RawW + RangeW;
  localparam int unsigned RecipW      = 32;
  localparam int unsigned RemW        = 32;

  localparam int unsigned LagLen      = 55;
  localparam int unsigned LagStep     = 21;
  localparam int unsigned SecondStart = 31;
  localparam int unsigned StirOffset  = 30;
  localparam int unsigned StirSplit   = LagLen - StirOffset - 1;
  localparam int unsigned StirPasses  = 4;
  localparam int unsigned TableDepth  = LagLen + 1;
  localparam int unsigned AddrW       = $clog2(TableDepth);
  localparam int unsigned AddrXW      = AddrW + 1;
  localparam int unsigned PassW       = $clog2(StirPasses);

  localparam logic [RawW-1:0] Modulus    = RawW'(1000000000);
  localparam logic [RawW-1:0] MagicReset = RawW'(161803398);

  // Reciprocal of the modulus scaled by 2^ProdW, applied to the top RecipW
  // bits of the range product.
  localparam logic [RecipW-1:0] Recip        = RecipW'((64'd1 << ProdW) / 64'(Modulus));
  localparam logic [RemW-1:0]   TwiceModulus = RemW'({Modulus, 1'b0});

  function automatic logic [RawW-1:0] sub_mod(input logic [RawW-1:0] a,
                                               input logic [RawW-1:0] b);
    logic [RawW:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    if (diff[RawW]) begin
      return diff[RawW-1:0] + Modulus;
    end
    return diff[RawW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p);
    logic [AddrW-1:0] q;
    q = p + AddrW'(1);
    return (q > AddrW'(LagLen)) ? AddrW'(1) : q;
  endfunction

  function automatic logic [AddrW-1:0] fill_next(input logic [AddrW-1:0] idx);
    logic [AddrXW-1:0] sum;
    sum = {1'b0, idx} + AddrXW'(LagStep);
    if (sum >= AddrXW'(LagLen)) begin
      return AddrW'(sum - AddrXW'(LagLen));
    end
    return sum[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] stir_partner(input logic [AddrW-1:0] idx);
    if (idx <= AddrW'(StirSplit)) begin
      return idx + AddrW'(StirOffset + 1);
    end
    return idx - AddrW'(StirSplit);
  endfunction

endpackage

FILE: rtl/srg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with the read data registered.
// ----------------------------------------------------------------------------
module srg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/srg_div.sv
// ----------------------------------------------------------------------------
// Scaling divider
// Division of the range product by the modulus through a reciprocal
// multiplication and a short correction, in estimate, remainder and fix steps.
// ----------------------------------------------------------------------------
module srg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [srg_pkg::ProdW-1:0]  dividend_i,
  output logic                       done_o,
  output logic [srg_pkg::RangeW-1:0] quotient_o
);

  import srg_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_EST  = 2'd1;
  localparam logic [1:0] D_REM  = 2'd2;
  localparam logic [1:0] D_FIX  = 2'd3;

  // The estimate taken from the top bits of the product falls short of the
  // quotient by at most two, so two comparisons of the remainder finish it.
  logic [1:0]          stage_q, stage_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [RangeW-1:0]   est_q, est_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RangeW-1:0]   quo_q, quo_d;
  logic [2*RecipW-1:0] est_full;
  logic [ProdW-1:0]    rem_full;
  logic                fix_one;
  logic                fix_two;

  assign est_full = prod_q[ProdW-1 -: RecipW] * Recip;
  assign rem_full = prod_q - est_q * Modulus;
  assign fix_one  = rem_q >= RemW'(Modulus);
  assign fix_two  = rem_q >= TwiceModulus;

  always_comb begin
    stage_d = stage_q;
    prod_d  = prod_q;
    est_d   = est_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    unique case (stage_q)
      D_IDLE: begin
        if (start_i) begin
          prod_d  = dividend_i;
          stage_d = D_EST;
        end
      end
      D_EST: begin
        est_d   = est_full[2*RecipW-2:RecipW];
        stage_d = D_REM;
      end
      D_REM: begin
        rem_d   = rem_full[RemW-1:0];
        stage_d = D_FIX;
      end
      D_FIX: begin
        quo_d   = est_q + RangeW'(fix_one) + RangeW'(fix_two);
        stage_d = D_IDLE;
      end
      default: begin
        stage_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= D_IDLE;
    end else begin
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    est_q  <= est_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign done_o     = stage_q == D_FIX;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/subtractive_random_generator.sv
// ----------------------------------------------------------------------------
// Subtractive random generator
// Lagged subtractive generator with lags 24 and 55 over a 55-entry table held
// in a RAM. Each transaction returns a draw below the modulus, the draw scaled
// to [0, range_n_i) and the seed to hand back. A draw runs from acceptance to
// result in steps: read two table entries and write one back, form the range
// product, divide it by the modulus through a reciprocal multiplication with
// a final correction, and load the output register. The block accepts again
// in the cycle after that, and a result that is not taken holds the next one
// in its last step. A transaction with a negative seed, and the first after
// reset, rebuilds the table first: it saturates the seed, fans it out in 55
// writes and stirs it in 220 read and write-back steps. The next transaction
// is accepted while a finished result still waits on the output.
// ----------------------------------------------------------------------------
module subtractive_random_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              seed_magic_we_i,
  input  logic [srg_pkg::RawW-1:0]          seed_magic_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [srg_pkg::SeedW-1:0]  seed_value_i,
  input  logic [srg_pkg::RangeW-1:0]        range_n_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srg_pkg::RawW-1:0]          raw_value_o,
  output logic [srg_pkg::RangeW-1:0]        scaled_index_o,
  output logic signed [srg_pkg::SeedW-1:0]  seed_after_o
);

  import srg_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SEED    = 4'd1;
  localparam logic [3:0] S_FILL0   = 4'd2;
  localparam logic [3:0] S_FILL    = 4'd3;
  localparam logic [3:0] S_STIR_RD = 4'd4;
  localparam logic [3:0] S_STIR_WR = 4'd5;
  localparam logic [3:0] S_DRAW_RD = 4'd6;
  localparam logic [3:0] S_DRAW_WR = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]        state_q, state_d;
  logic              seeded_q, seeded_d;
  logic [AddrW-1:0]  fp_q, fp_d;
  logic [AddrW-1:0]  sp_q, sp_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic [PassW-1:0]  pass_q, pass_d;
  logic [RawW-1:0]   magic_q;
  logic              out_valid_q, out_valid_d;

  logic [SeedW-1:0]  mag_q, mag_d;
  logic [RangeW-1:0] range_q, range_d;
  logic [SeedW-1:0]  seed_out_q, seed_out_d;
  logic [RawW-1:0]   diff_q, diff_d;
  logic [RawW-1:0]   cur_q, cur_d;
  logic [RawW-1:0]   prev_q, prev_d;
  logic [RawW-1:0]   raw_q, raw_d;
  logic [RawW-1:0]   raw_value_q, raw_value_d;
  logic [RangeW-1:0] scaled_index_q, scaled_index_d;
  logic [SeedW-1:0]  seed_after_q, seed_after_d;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [RawW-1:0]   mem_wdata;
  logic [AddrW-1:0]  mem_raddr_a;
  logic [AddrW-1:0]  mem_raddr_b;
  logic [RawW-1:0]   mem_rdata_a;
  logic [RawW-1:0]   mem_rdata_b;

  logic [SeedW-1:0]  seed_bits;
  logic              seed_neg;
  logic              need_build;
  logic [RawW-1:0]   mix;
  logic [RawW-1:0]   first_entry;
  logic [ProdW-1:0]  prod;
  logic              div_start;
  logic              div_done;
  logic [RangeW-1:0] div_quotient;

  assign seed_bits   = seed_value_i;
  assign seed_neg    = seed_bits[SeedW-1];
  assign need_build  = seed_neg || !seeded_q;
  assign mix         = sub_mod(mem_rdata_a, mem_rdata_b);
  assign first_entry = (diff_q >= Modulus) ? diff_q - Modulus : diff_q;
  assign prod        = range_q * raw_q;
  assign div_start   = state_q == S_MUL;

  assign mem_raddr_a = (state_q == S_DRAW_RD) ? next_ptr(fp_q) : idx_q;
  assign mem_raddr_b = (state_q == S_DRAW_RD) ? next_ptr(sp_q) : stir_partner(idx_q);

  always_comb begin
    state_d        = state_q;
    seeded_d       = seeded_q;
    fp_d           = fp_q;
    sp_d           = sp_q;
    idx_d          = idx_q;
    cnt_d          = cnt_q;
    pass_d         = pass_q;
    out_valid_d    = out_valid_q;
    mag_d          = mag_q;
    range_d        = range_q;
    seed_out_d     = seed_out_q;
    diff_d         = diff_q;
    cur_d          = cur_q;
    prev_d         = prev_q;
    raw_d          = raw_q;
    raw_value_d    = raw_value_q;
    scaled_index_d = scaled_index_q;
    seed_after_d   = seed_after_q;
    mem_we         = 1'b0;
    mem_waddr      = idx_q;
    mem_wdata      = mix;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mag_d      = seed_neg ? ~seed_bits + SeedW'(1) : seed_bits;
          range_d    = range_n_i;
          seed_out_d = need_build ? SeedW'(1) : seed_bits;
          state_d    = need_build ? S_SEED : S_DRAW_RD;
        end
      end
      S_SEED: begin
        diff_d  = (mag_q > SeedW'(magic_q)) ? '0 : magic_q - mag_q[RawW-1:0];
        state_d = S_FILL0;
      end
      S_FILL0: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(LagLen);
        mem_wdata = first_entry;
        cur_d     = first_entry;
        prev_d    = RawW'(1);
        idx_d     = AddrW'(LagStep);
        cnt_d     = '0;
        state_d   = S_FILL;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = prev_q;
        prev_d    = sub_mod(cur_q, prev_q);
        cur_d     = prev_q;
        if (cnt_q == AddrW'(LagLen - 2)) begin
          idx_d   = AddrW'(1);
          pass_d  = '0;
          state_d = S_STIR_RD;
        end else begin
          idx_d = fill_next(idx_q);
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      S_STIR_RD: begin
        state_d = S_STIR_WR;
      end
      S_STIR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = mix;
        if (idx_q == AddrW'(LagLen)) begin
          idx_d = AddrW'(1);
          if (pass_q == PassW'(StirPasses - 1)) begin
            fp_d     = '0;
            sp_d     = AddrW'(SecondStart);
            seeded_d = 1'b1;
            state_d  = S_DRAW_RD;
          end else begin
            pass_d  = pass_q + PassW'(1);
            state_d = S_STIR_RD;
          end
        end else begin
          idx_d   = idx_q + AddrW'(1);
          state_d = S_STIR_RD;
        end
      end
      S_DRAW_RD: begin
        fp_d    = next_ptr(fp_q);
        sp_d    = next_ptr(sp_q);
        state_d = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = fp_q;
        mem_wdata = mix;
        raw_d     = mix;
        state_d   = S_MUL;
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          raw_value_d    = raw_q;
          scaled_index_d = div_quotient;
          seed_after_d   = seed_out_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      fp_q        <= '0;
      sp_q        <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      pass_q      <= '0;
      magic_q     <= MagicReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      fp_q        <= fp_d;
      sp_q        <= sp_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      if (seed_magic_we_i) begin
        magic_q <= seed_magic_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q          <= mag_d;
    range_q        <= range_d;
    seed_out_q     <= seed_out_d;
    diff_q         <= diff_d;
    cur_q          <= cur_d;
    prev_q         <= prev_d;
    raw_q          <= raw_d;
    raw_value_q    <= raw_value_d;
    scaled_index_q <= scaled_index_d;
    seed_after_q   <= seed_after_d;
  end

  srg_ram #(
    .Width (RawW),
    .Depth (TableDepth)
  ) u_lag_table (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .rdata_a_o (mem_rdata_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_b_o (mem_rdata_b)
  );

  srg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign in_ready_o     = state_q == S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = raw_value_q;
  assign scaled_index_o = scaled_index_q;
  assign seed_after_o   = seed_after_q;

endmodule

FILE: rtl/srg_checker.sv
// ----------------------------------------------------------------------------
// Subtractive random generator checker
// Port-level assertions, bound to the generator top level.
// ----------------------------------------------------------------------------
module srg_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [srg_pkg::RawW-1:0]          raw_value_o,
  input  logic [srg_pkg::RangeW-1:0]        scaled_index_o,
  input  logic signed [srg_pkg::SeedW-1:0]  seed_after_o
);

  import srg_pkg::*;

  // Transactions accepted on the input but not yet taken on the output.
  logic [1:0] pending_q, pending_d;
  logic       seen_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seen_q    <= 1'b0;
    end else begin
      pending_q <= pending_d;
      if (out_acc) begin
        seen_q <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> raw_value_o < Modulus)
    else $error("Draw is not below the modulus.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !seen_q |-> seed_after_o == SeedW'(1))
    else $error("First result after reset does not report a rebuilt table.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o |-> pending_q != 2'd0) and (pending_q != 2'd3))
    else $error("Results do not match accepted transactions.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(raw_value_o)
      && $stable(scaled_index_o) && $stable(seed_after_o))
    else $error("Stalled result changed before it was taken.");

endmodule

bind subtractive_random_generator srg_checker u_srg_checker (.*);
